[rtl/fqs_pkg.sv]
// Shared types and constants of the searchable queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package fqs_pkg;

    // Field widths of the stream words
    localparam int OP_W       = 2;
    localparam int DATA_W     = 32;
    localparam int DIST_W     = 5;
    localparam int OCC_W      = 5;
    localparam int ST_W       = 2;
    localparam int OUT_DATA_W = 80;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_PUSH_FULL = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // latch the incoming word, clear result fields
        logic push;        // write at tail, advance tail, count up
        logic push_full;   // flag dropped push
        logic pop;         // take head word, advance head, count down
        logic pop_empty;   // flag ignored pop
        logic head_load;   // refresh head word from the RAM read data
        logic scan_start;  // begin search at the head
        logic scan_step;   // move search to the next entry
        logic found;       // record match distance
        logic out_load;    // load the output register
    } t_fqs_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            match;
        logic            scan_last;
        logic            out_free;
    } t_fqs_stat;

endpackage

`default_nettype wire

[rtl/fqs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/fqs_ctrl.sv]
// Controller of the searchable queue: sequences one operation at a time.
// Depends on fqs_pkg for the command and status structs and the codes.
`default_nettype none

module fqs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire fqs_pkg::t_fqs_stat i_stat,
    output fqs_pkg::t_fqs_cmd      o_cmd
);

    import fqs_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_POPWAIT = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_OUT     = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_OUT;
                case (i_stat.op)
                    OP_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.push_full = 1'b1;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.pop_empty = 1'b1;
                        end else begin
                            o_cmd.pop = 1'b1;
                            n_state   = S_POPWAIT;
                        end
                    end
                    OP_SEARCH: begin
                        if (!i_stat.empty) begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_POPWAIT: begin
                o_cmd.head_load = 1'b1;
                n_state         = S_OUT;
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.found = 1'b1;
                    n_state     = S_OUT;
                end else if (i_stat.scan_last) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted word always goes to decode next
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted word did not enter decode");

    // A search hit ends the scan at once
    a_hit_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_stat.match) |=> (r_state == S_OUT))
        else $error("search hit did not end the scan");

endmodule

`default_nettype wire

[rtl/fqs_dpath.sv]
// Datapath of the searchable queue: ring pointers, entry RAM, scan counter,
// result and output registers. Depends on fqs_pkg and fqs_ram.
`default_nettype none

module fqs_dpath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int WORD_WIDTH  = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [fqs_pkg::OP_W-1:0]        i_op,
    input  wire logic [fqs_pkg::DATA_W-1:0]      i_value,
    input  wire fqs_pkg::t_fqs_cmd               i_cmd,
    output fqs_pkg::t_fqs_stat                   o_stat,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic [fqs_pkg::OUT_DATA_W-1:0]       o_out_data,
    output logic [fqs_pkg::ST_W-1:0]             o_out_status
);

    import fqs_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        return (idx == AW'(QUEUE_DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    logic [OP_W-1:0]       r_op;
    logic [WORD_WIDTH-1:0] r_word;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         r_tail;
    logic [CW-1:0]         r_count;
    logic [WORD_WIDTH-1:0] r_head_word;
    logic [AW-1:0]         r_scan_idx;
    logic [CW-1:0]         r_scan_k;
    logic [DATA_W-1:0]     r_popped;
    logic [DIST_W-1:0]     r_dist;
    logic [ST_W-1:0]       r_status;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [ST_W-1:0]       r_out_status;

    logic [AW-1:0]         raddr;
    logic [WORD_WIDTH-1:0] rdata;
    logic                  is_empty;
    logic                  is_full;
    logic [DATA_W-1:0]     head_out;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CW'(QUEUE_DEPTH));
    assign head_out = is_empty ? '0 : DATA_W'(r_head_word);

    // Read address: next head on pop, head to start a scan, next entry while scanning
    always_comb begin
        raddr = r_head;
        if (i_cmd.pop) begin
            raddr = ring_next(r_head);
        end else if (i_cmd.scan_step) begin
            raddr = ring_next(r_scan_idx);
        end
    end

    fqs_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_tail),
        .i_wdata (r_word),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Status back to the controller
    always_comb begin
        o_stat.op        = r_op;
        o_stat.empty     = is_empty;
        o_stat.full      = is_full;
        o_stat.match     = (rdata == r_word);
        o_stat.scan_last = ((r_scan_k + CW'(1)) == r_count);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // Ring pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_tail  <= ring_next(r_tail);
            r_count <= r_count + CW'(1);
        end else if (i_cmd.pop) begin
            r_head  <= ring_next(r_head);
            r_count <= r_count - CW'(1);
        end
    end

    // Input word, head copy, scan position and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_word   <= WORD_WIDTH'(i_value);
            r_popped <= '0;
            r_dist   <= '1;
            r_status <= ST_OK;
        end
        if (i_cmd.push && is_empty) begin
            r_head_word <= r_word;
        end
        if (i_cmd.head_load) begin
            r_head_word <= rdata;
        end
        if (i_cmd.push_full) begin
            r_status <= ST_PUSH_FULL;
        end
        if (i_cmd.pop_empty) begin
            r_status <= ST_POP_EMPTY;
        end
        if (i_cmd.pop) begin
            r_popped <= DATA_W'(r_head_word);
        end
        if (i_cmd.scan_start) begin
            r_scan_idx <= r_head;
            r_scan_k   <= '0;
        end
        if (i_cmd.scan_step) begin
            r_scan_idx <= ring_next(r_scan_idx);
            r_scan_k   <= r_scan_k + CW'(1);
        end
        if (i_cmd.found) begin
            r_dist <= DIST_W'(r_scan_k);
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data   <= {4'b0000, OCC_W'(r_count), is_full, is_empty,
                             head_out, r_dist, r_popped};
            r_out_status <= r_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;

    // Occupancy never exceeds the ring
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    // Pointers meet exactly when the ring is empty or full
    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) == (is_empty || is_full))
        else $error("ring pointers disagree with occupancy");

endmodule

`default_nettype wire

[rtl/fifo_queue_with_search_unit.sv]
// Top level of the searchable queue: controller, datapath and entry RAM.
// Depends on fqs_pkg, fqs_ctrl, fqs_dpath and fqs_ram.
//
// A bounded FIFO of words held in a ring of QUEUE_DEPTH entries in one RAM
// with a single read port. Each input word carries an operation in tuser
// (push, pop, search) and a value in tdata; each produces exactly one output
// word with the popped value, the search distance (-1 when absent or not a
// search), the head value, empty and full flags, occupancy, and a status in
// tuser (ok, pop on empty ignored, push on full dropped). One operation is
// handled at a time. Push, a refused pop, a search on an empty queue and the
// unused code go through accept, decode and output load. A pop adds one RAM
// read between decode and output load to fetch the new head. A search scans
// between decode and output load, from the head until a match or through the
// occupancy: the scan reads one entry per cycle through the RAM read port.
// While the output register stays full, the output load waits. The output
// register holds a result until it is taken while the next word is accepted.
// The RAM needs no clearing after reset; entries that were never written are
// never shown.
`default_nettype none

module fifo_queue_with_search_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int WORD_WIDTH  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // [31:0] popped_value, [36:32] match_distance,
                                             // [68:37] head_value, [69] queue_empty,
                                             // [70] queue_full, [75:71] occupancy, [79:76] zero
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    import fqs_pkg::*;

    t_fqs_cmd  cmd;
    t_fqs_stat stat;

    fqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fqs_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (s_axis_tuser),
        .i_value      (s_axis_tdata),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

endmodule

`default_nettype wire
